// ===== rtl/ists_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the integer stack with search.
// Used by the control unit, the storage cells and the top level.
package ists_pkg;

  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int CAP_W     = 7;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes carried by an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  // Commands broadcast from the control unit to every cell.
  typedef struct packed {
    logic push;        // every cell takes the word of its upper neighbor
    logic pop;         // every cell takes the word of its lower neighbor
    logic load_match;  // every cell compares its word against the key
    logic shift_match; // match flags move one cell toward the top
  } cell_cmd_t;

endpackage

// ===== rtl/ists_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the stack chain: a data word and a match flag.
// Depends on ists_pkg for the data width and the command struct.
module ists_cell (
  input  logic                        clk,
  input  ists_pkg::cell_cmd_t         cmd,
  input  logic [ists_pkg::DATA_W-1:0] key,
  input  logic [ists_pkg::DATA_W-1:0] up_data,
  input  logic [ists_pkg::DATA_W-1:0] dn_data,
  input  logic                        dn_match,
  output logic [ists_pkg::DATA_W-1:0] data,
  output logic                        match
);
  import ists_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic              match_r;

  // Word moves down on a push and up on a pop; the flag records a key hit.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      data_r <= up_data;
    end else if (cmd.pop) begin
      data_r <= dn_data;
    end
    if (cmd.load_match) begin
      match_r <= (data_r == key);
    end else if (cmd.shift_match) begin
      match_r <= dn_match;
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

// ===== rtl/ists_ctrl.sv =====
`timescale 1ns / 1ps
// Control unit: entry count, capacity register, search scan and result register.
// Depends on ists_pkg; drives the command struct of the cell chain.
module ists_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ists_pkg::MODE_W-1:0]  in_mode,
  input  logic [ists_pkg::DATA_W-1:0]  top_data,
  input  logic                         head_match,
  output ists_pkg::cell_cmd_t          cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [ists_pkg::DATA_W-1:0]  out_data_out,
  output logic [ists_pkg::POS_W-1:0]   out_found_position,
  output logic [ists_pkg::COUNT_W-1:0] out_entry_count,
  output logic                         out_is_empty,
  output logic                         out_is_full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ists_pkg::CAP_W-1:0]   cfg_capacity
);
  import ists_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                status_r, status_nxt;
  logic [DATA_W-1:0]   data_r, data_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [COUNT_W-1:0]  ecount_r, ecount_nxt;
  logic                empty_r, empty_nxt;
  logic                full_r, full_nxt;

  logic                slot_free;
  logic                emit;
  logic                res_status;
  logic [DATA_W-1:0]   res_data;
  logic [W-1:0]        res_pos;
  logic [W-1:0]        cap_ext;
  logic [W-1:0]        cap_eff;
  logic [W-1:0]        cnt_ext_nxt;

  // Capacity above the storage depth saturates to the depth.
  assign cap_ext = W'(cap_r);
  assign cap_eff = (cap_ext > W'(DEPTH)) ? W'(DEPTH) : cap_ext;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign cfg_ready = 1'b1;

  // Operation decode, search scan and result formation.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cap_nxt       = cap_r;
    cmd           = '0;
    emit          = 1'b0;
    res_status    = 1'b1;
    res_data      = '0;
    res_pos       = '0;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_valid) begin
      cap_nxt = cfg_capacity;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid && slot_free) begin
          emit = 1'b1;
          case (in_mode)
            MODE_PUSH: begin
              if (W'(count_r) < cap_eff) begin
                cmd.push   = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                res_status = 1'b0;
              end
            end
            MODE_POP: begin
              if (count_r != '0) begin
                cmd.pop    = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
                res_data   = top_data;
                res_status = 1'b0;
              end
            end
            MODE_PEEK: begin
              if (count_r != '0) begin
                res_data   = top_data;
                res_status = 1'b0;
              end
            end
            MODE_SEARCH: begin
              emit           = 1'b0;
              cmd.load_match = 1'b1;
              idx_nxt        = '0;
              state_nxt      = ST_SCAN;
            end
            MODE_CLEAR: begin
              count_nxt  = '0;
              res_status = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Cell idx_r's match flag sits at the head of the chain this cycle.
        if (slot_free) begin
          if (idx_r == count_r) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end else if (head_match) begin
            emit       = 1'b1;
            res_status = 1'b0;
            res_pos    = W'(count_r) - W'(idx_r) - W'(1);
            state_nxt  = ST_IDLE;
          end else begin
            cmd.shift_match = 1'b1;
            idx_nxt         = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result register load; flags are taken after the operation.
    cnt_ext_nxt = W'(count_nxt);
    status_nxt  = status_r;
    data_nxt    = data_r;
    pos_nxt     = pos_r;
    ecount_nxt  = ecount_r;
    empty_nxt   = empty_r;
    full_nxt    = full_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res_status;
      data_nxt      = res_data;
      pos_nxt       = res_pos[POS_W-1:0];
      ecount_nxt    = cnt_ext_nxt[COUNT_W-1:0];
      empty_nxt     = (count_nxt == '0);
      full_nxt      = (cnt_ext_nxt >= cap_eff);
    end
  end

  // State, counters, capacity and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    data_r   <= data_nxt;
    pos_r    <= pos_nxt;
    ecount_r <= ecount_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_data_out       = data_r;
  assign out_found_position = pos_r;
  assign out_entry_count    = ecount_r;
  assign out_is_empty       = empty_r;
  assign out_is_full        = full_r;

endmodule

// ===== rtl/integer_stack_with_search_unit.sv =====
`timescale 1ns / 1ps
// LIFO stack of signed 32-bit words held in a chain of cells, top entry in cell 0.
// Push, pop, peek, clear: one item per cycle while idle and not stalled by out_ready;
// the result register loads on accept. Search: compares all cells at accept, then walks
// match flags to the head one cell per cycle until a hit, or a miss once count cells are walked.
// Synchronous active-low reset empties the stack and sets capacity to 64; cell
// contents are not reset.
module integer_stack_with_search_unit #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ists_pkg::MODE_W-1:0]  in_mode,
  input  logic signed [ists_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic signed [ists_pkg::DATA_W-1:0] out_data_out,
  output logic [ists_pkg::POS_W-1:0]   out_found_position,
  output logic [ists_pkg::COUNT_W-1:0] out_entry_count,
  output logic                         out_is_empty,
  output logic                         out_is_full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ists_pkg::CAP_W-1:0]   cfg_capacity
);
  import ists_pkg::*;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_match [DEPTH];
  logic [DATA_W-1:0] data_out_u;

  // Control unit.
  ists_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .top_data           (cell_data[0]),
    .head_match         (cell_match[0]),
    .cmd                (cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_data_out       (data_out_u),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity       (cfg_capacity)
  );

  assign out_data_out = $signed(data_out_u);

  // Chain of cells; cell 0 takes the pushed word, the last cell takes zero on a pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_d;
    logic [DATA_W-1:0] dn_d;
    logic              dn_m;

    if (i == 0) begin : g_head
      assign up_d = $unsigned(in_value);
    end else begin : g_mid_up
      assign up_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_d = '0;
      assign dn_m = 1'b0;
    end else begin : g_mid_dn
      assign dn_d = cell_data[i+1];
      assign dn_m = cell_match[i+1];
    end

    ists_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .key      ($unsigned(in_value)),
      .up_data  (up_d),
      .dn_data  (dn_d),
      .dn_match (dn_m),
      .data     (cell_data[i]),
      .match    (cell_match[i])
    );
  end

endmodule

// ===== rtl/ists_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the integer stack with search, bound to the top level.
// Depends on ists_pkg for field widths.
module ists_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [ists_pkg::DATA_W-1:0]  out_data_out,
  input logic [ists_pkg::POS_W-1:0]   out_found_position,
  input logic [ists_pkg::COUNT_W-1:0] out_entry_count,
  input logic                         out_is_empty,
  input logic                         out_is_full
);
  import ists_pkg::*;

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_entry_count) && $stable(out_status)
      && $stable(out_is_full))
    else $error("result item changed while stalled");

  // The empty flag agrees with the reported count.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // A failed operation carries neither data nor a position.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_data_out == '0) && (out_found_position == '0))
    else $error("failed item carries data or position");

  // A reported match position lies below the entry count.
  a_pos_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && (out_found_position != '0)
      |-> COUNT_W'(out_found_position) < out_entry_count)
    else $error("match position at or above entry count");

  // An input item is taken only when the result slot can receive its item.
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input accepted with result slot blocked");

endmodule

bind integer_stack_with_search_unit ists_checker u_ists_checker (.*);
